FILE: hdl/rhat_pkg.sv
// Shared types, codes and the control program for the rectangle hit-area table.
// Used by rhat_store and rectangle_hit_area_table_core.
`default_nettype none

package rhat_pkg;

    localparam int MAX_RECTS_DEF = 64;

    localparam int SUM_W  = 36;
    localparam int PROD_W = 30;

    // commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_DEL   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // program counter values
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
    localparam logic [PC_W-1:0] PC_ADD    = 3'd1;
    localparam logic [PC_W-1:0] PC_DSCAN  = 3'd2;
    localparam logic [PC_W-1:0] PC_DSHIFT = 3'd3;
    localparam logic [PC_W-1:0] PC_QSCAN  = 3'd4;
    localparam logic [PC_W-1:0] PC_FINISH = 3'd5;

    // index ops
    localparam logic [1:0] IDX_HOLD    = 2'd0;
    localparam logic [1:0] IDX_CLR     = 2'd1;
    localparam logic [1:0] IDX_INC_NE  = 2'd2;

    // table write ops
    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_APPEND = 2'd1;
    localparam logic [1:0] WR_SHIFT  = 2'd2;

    // jump kinds
    localparam logic [2:0] J_GOTO     = 3'd0;
    localparam logic [2:0] J_DISPATCH = 3'd1;
    localparam logic [2:0] J_DSCAN    = 3'd2;
    localparam logic [2:0] J_LOOP_END = 3'd3;
    localparam logic [2:0] J_OUT      = 3'd4;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [14:0] w;
        logic [14:0] h;
    } entry_t;

    typedef struct packed {
        logic            in_ready;
        logic [1:0]      idx_op;
        logic [1:0]      wr_op;
        logic            cnt_dec_on_end;
        logic            nf_on_end;
        logic            mul_en;
        logic            out_load;
        logic [2:0]      jmp;
        logic [PC_W-1:0] target;
    } cw_t;

    // control store: one word per step
    function automatic cw_t rom_word(input logic [PC_W-1:0] pc);
        cw_t w;
        w = '{in_ready: 1'b0, idx_op: IDX_HOLD, wr_op: WR_NONE, cnt_dec_on_end: 1'b0,
              nf_on_end: 1'b0, mul_en: 1'b0, out_load: 1'b0, jmp: J_GOTO,
              target: PC_IDLE};
        unique case (pc)
            PC_IDLE: begin
                w.in_ready = 1'b1;
                w.idx_op   = IDX_CLR;
                w.jmp      = J_DISPATCH;
            end
            PC_ADD: begin
                w.wr_op  = WR_APPEND;
                w.target = PC_FINISH;
            end
            PC_DSCAN: begin
                w.idx_op    = IDX_INC_NE;
                w.nf_on_end = 1'b1;
                w.jmp       = J_DSCAN;
                w.target    = PC_FINISH;
            end
            PC_DSHIFT: begin
                w.idx_op         = IDX_INC_NE;
                w.wr_op          = WR_SHIFT;
                w.cnt_dec_on_end = 1'b1;
                w.jmp            = J_LOOP_END;
                w.target         = PC_FINISH;
            end
            PC_QSCAN: begin
                w.idx_op = IDX_INC_NE;
                w.mul_en = 1'b1;
                w.jmp    = J_LOOP_END;
                w.target = PC_FINISH;
            end
            PC_FINISH: begin
                w.out_load = 1'b1;
                w.jmp      = J_OUT;
                w.target   = PC_IDLE;
            end
            default: begin
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] dispatch_pc(input logic [1:0] cmd);
        logic [PC_W-1:0] pc;
        unique case (cmd)
            CMD_ADD:   pc = PC_ADD;
            CMD_DEL:   pc = PC_DSCAN;
            CMD_QUERY: pc = PC_QSCAN;
            default:   pc = PC_FINISH;
        endcase
        return pc;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rhat_store.sv
// Rectangle table storage: one write port, one read port with registered data.
// Depends on rhat_pkg for the entry type.
`default_nettype none

module rhat_store #(
    parameter int DEPTH = rhat_pkg::MAX_RECTS_DEF,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire rhat_pkg::entry_t wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output rhat_pkg::entry_t      rd_data
);
    import rhat_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/rectangle_hit_area_table_core.sv
// Rectangle hit-area table, top level: microcoded sequencer and datapath.
// Depends on rhat_pkg and rhat_store.
`default_nettype none

// An add appends the entry if the table has room and then presents its result, and
// an unused command goes straight to the last step; a delete or a query walks the
// table through its single read port one entry per cycle (a delete keeps walking
// to close the gap). The input is ready again the cycle after the result is loaded.
// The result sits in an output register, so the next word is taken while the
// previous result waits; the sequencer holds in its last step only while that
// register is still occupied and not being taken.
// A query returns the 36-bit sum, saturating at its maximum, of the areas of
// rectangles that strictly contain the point.
module rectangle_hit_area_table_core #(
    parameter int MAX_RECTS = rhat_pkg::MAX_RECTS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_command,
    input  wire logic [15:0]        s_rect_id,
    input  wire logic signed [15:0] s_corner_x,
    input  wire logic signed [15:0] s_corner_y,
    input  wire logic [14:0]        s_rect_width,
    input  wire logic [14:0]        s_rect_height,
    input  wire logic signed [15:0] s_point_x,
    input  wire logic signed [15:0] s_point_y,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [35:0]             m_area_sum
);
    import rhat_pkg::*;

    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [1:0]      status_reg, status_next;
    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_status_reg;
    logic [SUM_W-1:0] m_area_sum_reg;
    entry_t          item_reg;
    logic signed [15:0] px_reg, py_reg;

    cw_t    cw;
    entry_t rd_entry;
    entry_t wr_entry;
    logic   wr_en;
    logic [AW-1:0] wr_addr;
    logic   accept, scan_end, id_match, full, out_free, hit;
    logic [CW-1:0] idx_dec;
    logic signed [17:0] cx_ext, cy_ext, px_ext, py_ext, right_x, bottom_y;
    logic [PROD_W-1:0] area;
    logic [SUM_W:0]    sum_ext;

    assign cw       = rom_word(pc_reg);
    assign s_ready  = cw.in_ready;
    assign accept   = s_valid && s_ready;
    assign scan_end = idx_reg >= cnt_reg;
    assign id_match = rd_entry.id == item_reg.id;
    assign full     = cnt_reg >= CW'(MAX_RECTS);
    assign out_free = !m_valid_reg || m_ready;
    assign idx_dec  = idx_reg - CW'(1);

    // hit test against the entry on the read port
    assign cx_ext   = 18'($signed(rd_entry.cx));
    assign cy_ext   = 18'($signed(rd_entry.cy));
    assign px_ext   = 18'(px_reg);
    assign py_ext   = 18'(py_reg);
    assign right_x  = cx_ext + $signed({3'b000, rd_entry.w});
    assign bottom_y = cy_ext + $signed({3'b000, rd_entry.h});
    assign hit      = (px_ext > cx_ext) && (px_ext < right_x) &&
                      (py_ext > cy_ext) && (py_ext < bottom_y);
    assign area     = {15'd0, rd_entry.w} * {15'd0, rd_entry.h};
    assign sum_ext  = {1'b0, sum_reg} + {{(SUM_W + 1 - PROD_W){1'b0}}, prod_reg};

    rhat_store #(
        .DEPTH (MAX_RECTS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (idx_next[AW-1:0]),
        .rd_data (rd_entry)
    );

    always_comb begin
        pc_next = pc_reg;
        unique case (cw.jmp)
            J_GOTO:     pc_next = cw.target;
            J_DISPATCH: pc_next = s_valid ? dispatch_pc(s_command) : pc_reg;
            J_DSCAN: begin
                if (scan_end) begin
                    pc_next = cw.target;
                end else if (id_match) begin
                    pc_next = pc_reg + PC_W'(1);
                end
            end
            J_LOOP_END: pc_next = scan_end ? cw.target : pc_reg;
            J_OUT:      pc_next = out_free ? cw.target : pc_reg;
            default:    pc_next = PC_IDLE;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        case (cw.idx_op)
            IDX_CLR:    idx_next = '0;
            IDX_INC_NE: idx_next = scan_end ? idx_reg : idx_reg + CW'(1);
            default:    idx_next = idx_reg;
        endcase
    end

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = cnt_reg[AW-1:0];
        wr_entry = item_reg;
        cnt_next = cnt_reg;
        case (cw.wr_op)
            WR_APPEND: begin
                if (!full) begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            WR_SHIFT: begin
                // move the entry one place down to close the gap
                wr_en    = !scan_end;
                wr_addr  = idx_dec[AW-1:0];
                wr_entry = rd_entry;
            end
            default: wr_en = 1'b0;
        endcase
        if (cw.cnt_dec_on_end && scan_end) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_comb begin
        status_next = status_reg;
        if (accept) begin
            status_next = ST_OK;
        end else if (cw.wr_op == WR_APPEND && full) begin
            status_next = ST_FULL;
        end else if (cw.nf_on_end && scan_end) begin
            status_next = ST_NOTFOUND;
        end
    end

    always_comb begin
        prod_next = (cw.mul_en && !scan_end && hit) ? area : '0;
        if (accept) begin
            sum_next = '0;
        end else if (sum_ext[SUM_W]) begin
            sum_next = '1;
        end else begin
            sum_next = sum_ext[SUM_W-1:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cw.out_load && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= PC_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            prod_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            prod_reg    <= prod_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        status_reg <= status_next;
        if (accept) begin
            item_reg <= '{id: s_rect_id, cx: s_corner_x, cy: s_corner_y,
                          w: s_rect_width, h: s_rect_height};
            px_reg   <= s_point_x;
            py_reg   <= s_point_y;
        end
        if (cw.out_load && out_free) begin
            m_status_reg   <= status_reg;
            m_area_sum_reg <= sum_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_area_sum = m_area_sum_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_RECTS))
        else $error("entry count above table size");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("word taken while another is in work");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + CW'(1)) ||
        (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_finish_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == PC_FINISH && out_free) |=> m_valid)
        else $error("finished word not presented");

endmodule

`default_nettype wire
